### sv/cmp_pkg.sv
`timescale 1ns / 1ps

package cmp_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    // result kinds
    localparam logic [2:0] KIND_HEADER    = 3'd0;
    localparam logic [2:0] KIND_TOKEN     = 3'd1;
    localparam logic [2:0] KIND_OPT_START = 3'd2;
    localparam logic [2:0] KIND_OPT_VALUE = 3'd3;
    localparam logic [2:0] KIND_PAYLOAD   = 3'd4;
    localparam logic [2:0] KIND_END       = 3'd5;

    // message status codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_SHORT       = 4'd1;
    localparam logic [3:0] ST_EMPTY_EXTRA = 4'd2;
    localparam logic [3:0] ST_TRUNC_TOKEN = 4'd3;
    localparam logic [3:0] ST_DELTA_RES   = 4'd4;
    localparam logic [3:0] ST_NO_PAYLOAD  = 4'd5;
    localparam logic [3:0] ST_TRUNC_OPT   = 4'd6;
    localparam logic [3:0] ST_OPT_RANGE   = 4'd7;
    localparam logic [3:0] ST_LEN_RES     = 4'd8;

    // option nibble codes
    localparam logic [3:0] NIB_EXT1 = 4'd13;
    localparam logic [3:0] NIB_EXT2 = 4'd14;
    localparam logic [3:0] NIB_RES  = 4'd15;

    localparam logic [16:0] EXT1_BIAS  = 17'd13;
    localparam logic [16:0] EXT2_BIAS  = 17'd269;
    localparam logic [17:0] MAX_OPTION = 18'd65535;

    typedef struct packed {
        logic [2:0]  rkind;
        logic [1:0]  version;
        logic [1:0]  msg_type;
        logic [3:0]  token_len;
        logic [2:0]  code_class;
        logic [4:0]  code_detail;
        logic [15:0] message_id;
        logic [7:0]  data_byte;
        logic [15:0] option_number;
        logic [16:0] option_length;
        logic [31:0] option_int;
    } t_result;

    // what one input byte causes: an optional field result and an optional message end
    typedef struct packed {
        logic       has_res;
        t_result    res;
        logic       has_end;
        logic [3:0] status;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### sv/cmp_front.sv
`timescale 1ns / 1ps

module cmp_front import cmp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_push,
    output t_entry     o_entry
);

    typedef enum logic [3:0] {
        PH_HDR, PH_TOKEN, PH_OPTH, PH_DX1, PH_DX2, PH_LX1, PH_LX2,
        PH_VALUE, PH_MARKER, PH_PAYLOAD, PH_DRAIN
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_byte_count, n_byte_count;
    logic [23:0] r_hold, n_hold;
    logic [3:0]  r_token_left, n_token_left;
    logic [15:0] r_cur_opt, n_cur_opt;
    logic [16:0] r_delta, n_delta;
    logic [16:0] r_length, n_length;
    logic [7:0]  r_nibbles, n_nibbles;
    logic [16:0] r_value_left, n_value_left;
    logic [31:0] r_int, n_int;
    logic [3:0]  r_error, n_error;

    t_entry      ent;
    logic        do_after;
    logic        do_fin;
    logic [3:0]  fail_code;
    logic [17:0] opt_sum;
    logic [3:0]  dnib;
    logic [3:0]  lnib;

    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_hold       = r_hold;
        n_token_left = r_token_left;
        n_cur_opt    = r_cur_opt;
        n_delta      = r_delta;
        n_length     = r_length;
        n_nibbles    = r_nibbles;
        n_value_left = r_value_left;
        n_int        = r_int;
        n_error      = r_error;
        ent          = '0;
        do_after     = 1'b0;
        do_fin       = 1'b0;
        fail_code    = ST_OK;
        opt_sum      = '0;
        dnib         = i_byte[7:4];
        lnib         = i_byte[3:0];

        case (r_phase)
            PH_HDR: begin
                if (r_byte_count < 2'd3) begin
                    n_hold       = {r_hold[15:0], i_byte};
                    n_byte_count = r_byte_count + 2'd1;
                end else begin
                    ent.has_res          = 1'b1;
                    ent.res.rkind        = KIND_HEADER;
                    ent.res.version      = r_hold[23:22];
                    ent.res.msg_type     = r_hold[21:20];
                    ent.res.token_len    = r_hold[19:16];
                    ent.res.code_class   = r_hold[15:13];
                    ent.res.code_detail  = r_hold[12:8];
                    ent.res.message_id   = {r_hold[7:0], i_byte};
                    n_token_left         = r_hold[19:16];
                    if (r_hold[15:8] == 8'd0 && !i_last) begin
                        fail_code = ST_EMPTY_EXTRA;
                    end else begin
                        n_phase = (r_hold[19:16] != 4'd0) ? PH_TOKEN : PH_OPTH;
                    end
                end
            end
            PH_TOKEN: begin
                ent.has_res       = 1'b1;
                ent.res.rkind     = KIND_TOKEN;
                ent.res.data_byte = i_byte;
                n_token_left      = r_token_left - 4'd1;
                if (n_token_left == 4'd0) begin
                    n_phase = PH_OPTH;
                end
            end
            PH_OPTH: begin
                if (dnib == NIB_RES) begin
                    if (lnib == NIB_RES) begin
                        n_phase = PH_MARKER;
                    end else begin
                        fail_code = ST_DELTA_RES;
                    end
                end else if (lnib == NIB_RES) begin
                    fail_code = ST_LEN_RES;
                end else begin
                    n_nibbles = i_byte;
                    n_delta   = (dnib < NIB_EXT1) ? {13'd0, dnib} : 17'd0;
                    n_length  = (lnib < NIB_EXT1) ? {13'd0, lnib} : 17'd0;
                    if (dnib >= NIB_EXT1) begin
                        n_phase = PH_DX1;
                    end else begin
                        do_after = 1'b1;
                    end
                end
            end
            PH_DX1: begin
                if (r_nibbles[7:4] == NIB_EXT1) begin
                    n_delta  = {9'd0, i_byte} + EXT1_BIAS;
                    do_after = 1'b1;
                end else begin
                    n_delta = {1'b0, i_byte, 8'd0};
                    n_phase = PH_DX2;
                end
            end
            PH_DX2: begin
                n_delta  = r_delta + {9'd0, i_byte} + EXT2_BIAS;
                do_after = 1'b1;
            end
            PH_LX1: begin
                if (r_nibbles[3:0] == NIB_EXT1) begin
                    n_length = {9'd0, i_byte} + EXT1_BIAS;
                    do_fin   = 1'b1;
                end else begin
                    n_length = {1'b0, i_byte, 8'd0};
                    n_phase  = PH_LX2;
                end
            end
            PH_LX2: begin
                n_length = r_length + {9'd0, i_byte} + EXT2_BIAS;
                do_fin   = 1'b1;
            end
            PH_VALUE: begin
                n_int                 = {r_int[23:0], i_byte};
                n_value_left          = r_value_left - 17'd1;
                ent.has_res           = 1'b1;
                ent.res.rkind         = KIND_OPT_VALUE;
                ent.res.data_byte     = i_byte;
                ent.res.option_number = r_cur_opt;
                ent.res.option_int    = n_int;
                if (n_value_left == 17'd0) begin
                    n_phase = PH_OPTH;
                end
            end
            PH_MARKER, PH_PAYLOAD: begin
                ent.has_res       = 1'b1;
                ent.res.rkind     = KIND_PAYLOAD;
                ent.res.data_byte = i_byte;
                n_phase           = PH_PAYLOAD;
            end
            default: begin
            end
        endcase

        // length nibble decides whether extended length bytes follow
        if (do_after) begin
            if (n_nibbles[3:0] == NIB_EXT1 || n_nibbles[3:0] == NIB_EXT2) begin
                n_phase = PH_LX1;
            end else begin
                do_fin = 1'b1;
            end
        end

        if (do_fin) begin
            opt_sum = {2'b00, r_cur_opt} + {1'b0, n_delta};
            if (opt_sum > MAX_OPTION) begin
                fail_code = ST_OPT_RANGE;
            end else begin
                n_cur_opt             = opt_sum[15:0];
                n_value_left          = n_length;
                n_int                 = '0;
                ent.has_res           = 1'b1;
                ent.res.rkind         = KIND_OPT_START;
                ent.res.option_number = opt_sum[15:0];
                ent.res.option_length = n_length;
                n_phase               = (n_length != 17'd0) ? PH_VALUE : PH_OPTH;
            end
        end

        if (fail_code != ST_OK) begin
            if (r_error == ST_OK) begin
                n_error = fail_code;
            end
            n_phase = PH_DRAIN;
        end

        if (i_last) begin
            ent.has_end = 1'b1;
            if (n_error != ST_OK) begin
                ent.status = n_error;
            end else begin
                case (n_phase)
                    PH_HDR:   ent.status = ST_SHORT;
                    PH_TOKEN: ent.status = ST_TRUNC_TOKEN;
                    PH_DX1, PH_DX2, PH_LX1, PH_LX2, PH_VALUE:
                              ent.status = ST_TRUNC_OPT;
                    PH_MARKER: ent.status = ST_NO_PAYLOAD;
                    default:  ent.status = ST_OK;
                endcase
            end
            n_phase      = PH_HDR;
            n_byte_count = '0;
            n_hold       = '0;
            n_token_left = '0;
            n_cur_opt    = '0;
            n_delta      = '0;
            n_length     = '0;
            n_nibbles    = '0;
            n_value_left = '0;
            n_int        = '0;
            n_error      = ST_OK;
        end

        o_entry = ent;
        o_push  = i_accept && (ent.has_res || ent.has_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HDR;
            r_byte_count <= '0;
            r_hold       <= '0;
            r_token_left <= '0;
            r_cur_opt    <= '0;
            r_delta      <= '0;
            r_length     <= '0;
            r_nibbles    <= '0;
            r_value_left <= '0;
            r_int        <= '0;
            r_error      <= ST_OK;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_hold       <= n_hold;
            r_token_left <= n_token_left;
            r_cur_opt    <= n_cur_opt;
            r_delta      <= n_delta;
            r_length     <= n_length;
            r_nibbles    <= n_nibbles;
            r_value_left <= n_value_left;
            r_int        <= n_int;
            r_error      <= n_error;
        end
    end

endmodule

### sv/cmp_queue.sv
`timescale 1ns / 1ps

module cmp_queue import cmp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    input  logic    i_pop,
    output t_entry  o_entry,
    output t_q_stat o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_slots [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_entry      = r_slots[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

### sv/cmp_back.sv
`timescale 1ns / 1ps

module cmp_back import cmp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_entry  i_entry,
    output logic    o_pop,
    input  logic    i_out_ready,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_last
);

    logic    r_have;
    logic    r_first_done;
    t_entry  r_ent;
    logic    r_oval;
    t_result r_ores;
    logic    r_olast;

    logic    can_load;
    logic    done_entry;
    t_result piece;
    t_result end_res;

    always_comb begin
        end_res           = '0;
        end_res.rkind     = KIND_END;
        end_res.data_byte = {4'd0, r_ent.status};
        can_load          = !r_oval || i_out_ready;
        if (r_ent.has_res && !r_first_done) begin
            piece      = r_ent.res;
            done_entry = !r_ent.has_end;
        end else begin
            piece      = end_res;
            done_entry = 1'b1;
        end
        o_pop = i_q_valid && (!r_have || (can_load && done_entry));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have       <= 1'b0;
            r_first_done <= 1'b0;
            r_oval       <= 1'b0;
        end else begin
            if (r_have && can_load) begin
                r_oval  <= 1'b1;
                r_ores  <= piece;
                r_olast <= done_entry;
            end else if (i_out_ready) begin
                r_oval <= 1'b0;
            end
            if (o_pop) begin
                r_ent        <= i_entry;
                r_have       <= 1'b1;
                r_first_done <= 1'b0;
            end else if (r_have && can_load) begin
                if (done_entry) begin
                    r_have <= 1'b0;
                end else begin
                    r_first_done <= 1'b1;
                end
            end
        end
    end

    assign o_valid = r_oval;
    assign o_res   = r_ores;
    assign o_last  = r_olast;

endmodule

### sv/coap_message_parser.sv
`timescale 1ns / 1ps

// CoAP message parser: takes one message byte per cycle (i_in_last on the final byte) and
// delivers header, token, option start, option value, payload and message end results.
// A byte enters every cycle while the queue between the parse front end and the result
// back end has room; the back end sends one result per cycle while the output is ready, so a
// final byte that also yields a field result leaves as two results, the field result and then
// the message end. A byte's first result passes through the queue slot written when the byte
// is accepted, the back end's entry register and the output register. The parser returns to
// its reset state after each message end.

module coap_message_parser import cmp_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_rkind,
    output logic [1:0]  o_version,
    output logic [1:0]  o_msg_type,
    output logic [3:0]  o_token_len,
    output logic [2:0]  o_code_class,
    output logic [4:0]  o_code_detail,
    output logic [15:0] o_message_id,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_option_number,
    output logic [16:0] o_option_length,
    output logic [31:0] o_option_int,
    output logic        o_last_of_run
);

    logic    w_accept;
    logic    w_push;
    t_entry  w_push_entry;
    t_entry  w_head;
    t_q_stat w_q_stat;
    logic    w_pop;
    t_result w_res;

    // front end takes a byte whenever the queue can absorb what it causes
    assign o_in_ready = !w_q_stat.full;
    assign w_accept   = i_in_valid && o_in_ready;

    // parse state machine: header, token, options, payload, drain after an error
    cmp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_in_byte),
        .i_last   (i_in_last),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    // per-byte result records between the two sides
    cmp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_head),
        .o_stat  (w_q_stat)
    );

    // splits each record into its results and drives the output register
    cmp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (!w_q_stat.empty),
        .i_entry     (w_head),
        .o_pop       (w_pop),
        .i_out_ready (i_out_ready),
        .o_valid     (o_out_valid),
        .o_res       (w_res),
        .o_last      (o_last_of_run)
    );

    assign o_rkind         = w_res.rkind;
    assign o_version       = w_res.version;
    assign o_msg_type      = w_res.msg_type;
    assign o_token_len     = w_res.token_len;
    assign o_code_class    = w_res.code_class;
    assign o_code_detail   = w_res.code_detail;
    assign o_message_id    = w_res.message_id;
    assign o_data_byte     = w_res.data_byte;
    assign o_option_number = w_res.option_number;
    assign o_option_length = w_res.option_length;
    assign o_option_int    = w_res.option_int;

`ifndef ASSERT_OFF
    // a message end is always the closing result of its byte
    a_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rkind == KIND_END |-> o_last_of_run)
        else $error("message end result without last_of_run");

    // only defined result kinds leave the block
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_rkind <= KIND_END)
        else $error("undefined result kind on output");

    // reset leaves the queue empty and the output idle
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");
`endif

endmodule

### tb/coap_parse_scoreboard_pkg.sv
`timescale 1ns / 1ps

package coap_parse_scoreboard_pkg;

    import cmp_pkg::*;

    typedef enum logic [3:0] {
        P_HEADER,
        P_TOKEN,
        P_OPT_HDR,
        P_DELTA_X1,
        P_DELTA_X2,
        P_LEN_X1,
        P_LEN_X2,
        P_VALUE,
        P_MARKER,
        P_PAYLOAD,
        P_DRAIN
    } parse_phase_e;

    typedef struct packed {
        t_result res;
        logic    last_of_run;
    } t_expect;

    class coap_parse_scoreboard;

        parse_phase_e phase;
        logic [1:0]   hdr_count;
        logic [23:0]  hdr_hold;
        logic [3:0]   tok_left;
        logic [16:0]  opt_num;
        logic [16:0]  delta_sum;
        logic [16:0]  len_sum;
        logic [7:0]   opt_nibbles;
        logic [16:0]  val_left;
        logic [31:0]  val_int;
        logic [3:0]   status_hold;

        t_result      run_q[$];
        t_expect      expected_q[$];
        int unsigned  n_errors;

        function new();
            n_errors = 0;
            clear();
        endfunction

        function void clear();
            phase       = P_HEADER;
            hdr_count   = '0;
            hdr_hold    = '0;
            tok_left    = '0;
            opt_num     = '0;
            delta_sum   = '0;
            len_sum     = '0;
            opt_nibbles = '0;
            val_left    = '0;
            val_int     = '0;
            status_hold = ST_OK;
        endfunction

        // first error wins, the rest of the message is dropped
        function void abort_msg(logic [3:0] code);
            if (status_hold == ST_OK)
                status_hold = code;
            phase = P_DRAIN;
        endfunction

        function void open_option();
            logic [17:0] total;
            t_result     r;
            total = {1'b0, opt_num} + {1'b0, delta_sum};
            if (total > MAX_OPTION) begin
                abort_msg(ST_OPT_RANGE);
                return;
            end
            opt_num  = total[16:0];
            val_left = len_sum;
            val_int  = '0;
            r = '0;
            r.rkind         = KIND_OPT_START;
            r.option_number = total[15:0];
            r.option_length = len_sum;
            run_q.push_back(r);
            phase = (val_left != 0) ? P_VALUE : P_OPT_HDR;
        endfunction

        function void after_delta();
            if (opt_nibbles[3:0] == NIB_EXT1 || opt_nibbles[3:0] == NIB_EXT2)
                phase = P_LEN_X1;
            else
                open_option();
        endfunction

        // one accepted byte: queue up the results it should cause
        function void note_byte(logic [7:0] b, logic last);
            t_result    r;
            logic [3:0] d_nib;
            logic [3:0] l_nib;
            logic [3:0] st;
            run_q.delete();
            r = '0;
            case (phase)
                P_HEADER: begin
                    if (hdr_count < 2'd3) begin
                        hdr_hold  = {hdr_hold[15:0], b};
                        hdr_count = hdr_count + 2'd1;
                    end else begin
                        r.rkind       = KIND_HEADER;
                        r.version     = hdr_hold[23:22];
                        r.msg_type    = hdr_hold[21:20];
                        r.token_len   = hdr_hold[19:16];
                        r.code_class  = hdr_hold[15:13];
                        r.code_detail = hdr_hold[12:8];
                        r.message_id  = {hdr_hold[7:0], b};
                        run_q.push_back(r);
                        tok_left = hdr_hold[19:16];
                        if (hdr_hold[15:8] == 8'h00 && !last)
                            abort_msg(ST_EMPTY_EXTRA);
                        else
                            phase = (tok_left != 0) ? P_TOKEN : P_OPT_HDR;
                    end
                end
                P_TOKEN: begin
                    r.rkind     = KIND_TOKEN;
                    r.data_byte = b;
                    run_q.push_back(r);
                    tok_left = tok_left - 4'd1;
                    if (tok_left == 0)
                        phase = P_OPT_HDR;
                end
                P_OPT_HDR: begin
                    d_nib = b[7:4];
                    l_nib = b[3:0];
                    if (d_nib == NIB_RES) begin
                        if (l_nib == NIB_RES)
                            phase = P_MARKER;
                        else
                            abort_msg(ST_DELTA_RES);
                    end else if (l_nib == NIB_RES) begin
                        abort_msg(ST_LEN_RES);
                    end else begin
                        opt_nibbles = b;
                        delta_sum   = (d_nib < NIB_EXT1) ? {13'd0, d_nib} : '0;
                        len_sum     = (l_nib < NIB_EXT1) ? {13'd0, l_nib} : '0;
                        if (d_nib >= NIB_EXT1)
                            phase = P_DELTA_X1;
                        else
                            after_delta();
                    end
                end
                P_DELTA_X1: begin
                    if (opt_nibbles[7:4] == NIB_EXT1) begin
                        delta_sum = {9'd0, b} + EXT1_BIAS;
                        after_delta();
                    end else begin
                        delta_sum = {1'b0, b, 8'h00};
                        phase = P_DELTA_X2;
                    end
                end
                P_DELTA_X2: begin
                    delta_sum = delta_sum + {9'd0, b} + EXT2_BIAS;
                    after_delta();
                end
                P_LEN_X1: begin
                    if (opt_nibbles[3:0] == NIB_EXT1) begin
                        len_sum = {9'd0, b} + EXT1_BIAS;
                        open_option();
                    end else begin
                        len_sum = {1'b0, b, 8'h00};
                        phase = P_LEN_X2;
                    end
                end
                P_LEN_X2: begin
                    len_sum = len_sum + {9'd0, b} + EXT2_BIAS;
                    open_option();
                end
                P_VALUE: begin
                    val_int  = {val_int[23:0], b};
                    val_left = val_left - 17'd1;
                    r.rkind         = KIND_OPT_VALUE;
                    r.data_byte     = b;
                    r.option_number = opt_num[15:0];
                    r.option_int    = val_int;
                    run_q.push_back(r);
                    if (val_left == 0)
                        phase = P_OPT_HDR;
                end
                P_MARKER, P_PAYLOAD: begin
                    r.rkind     = KIND_PAYLOAD;
                    r.data_byte = b;
                    run_q.push_back(r);
                    phase = P_PAYLOAD;
                end
                default: ;
            endcase

            if (last) begin
                st = status_hold;
                if (st == ST_OK) begin
                    case (phase)
                        P_HEADER:   st = ST_SHORT;
                        P_TOKEN:    st = ST_TRUNC_TOKEN;
                        P_DELTA_X1, P_DELTA_X2, P_LEN_X1, P_LEN_X2,
                        P_VALUE:    st = ST_TRUNC_OPT;
                        P_MARKER:   st = ST_NO_PAYLOAD;
                        default:    st = ST_OK;
                    endcase
                end
                r = '0;
                r.rkind     = KIND_END;
                r.data_byte = {4'h0, st};
                run_q.push_back(r);
                clear();
            end

            foreach (run_q[i])
                expected_q.push_back('{res: run_q[i], last_of_run: (i == run_q.size() - 1)});
        endfunction

        function void cmp_field(string name, longint unsigned want, longint unsigned seen);
            if (want != seen) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
                n_errors++;
            end
        endfunction

        function void check_result(t_result got, logic got_last);
            t_expect exp;
            if (expected_q.size() == 0) begin
                $error("rkind: expected none, got 0x%0h", got.rkind);
                n_errors++;
                return;
            end
            exp = expected_q.pop_front();
            cmp_field("rkind", exp.res.rkind, got.rkind);
            cmp_field("version", exp.res.version, got.version);
            cmp_field("msg_type", exp.res.msg_type, got.msg_type);
            cmp_field("token_len", exp.res.token_len, got.token_len);
            cmp_field("code_class", exp.res.code_class, got.code_class);
            cmp_field("code_detail", exp.res.code_detail, got.code_detail);
            cmp_field("message_id", exp.res.message_id, got.message_id);
            cmp_field("data_byte", exp.res.data_byte, got.data_byte);
            cmp_field("option_number", exp.res.option_number, got.option_number);
            cmp_field("option_length", exp.res.option_length, got.option_length);
            cmp_field("option_int", exp.res.option_int, got.option_int);
            cmp_field("last_of_run", exp.last_of_run, got_last);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

    import cmp_pkg::*;
    import coap_parse_scoreboard_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_in_byte;
    logic        i_in_last;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_rkind;
    logic [1:0]  o_version;
    logic [1:0]  o_msg_type;
    logic [3:0]  o_token_len;
    logic [2:0]  o_code_class;
    logic [4:0]  o_code_detail;
    logic [15:0] o_message_id;
    logic [7:0]  o_data_byte;
    logic [15:0] o_option_number;
    logic [16:0] o_option_length;
    logic [31:0] o_option_int;
    logic        o_last_of_run;

    coap_parse_scoreboard sb = new();

    // current message, sent front to back with the flag on the final byte
    logic [7:0]  msg_q[$];
    int unsigned n_sent;
    int unsigned big_left;
    bit          holdoff_done;

    always #10 i_clk = ~i_clk;

    coap_message_parser u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .i_in_last       (i_in_last),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_rkind         (o_rkind),
        .o_version       (o_version),
        .o_msg_type      (o_msg_type),
        .o_token_len     (o_token_len),
        .o_code_class    (o_code_class),
        .o_code_detail   (o_code_detail),
        .o_message_id    (o_message_id),
        .o_data_byte     (o_data_byte),
        .o_option_number (o_option_number),
        .o_option_length (o_option_length),
        .o_option_int    (o_option_int),
        .o_last_of_run   (o_last_of_run)
    );

    // stretch of the run where neither side idles
    function automatic bit no_idle_window();
        return n_sent >= 700 && n_sent < 1000;
    endfunction

    // ------------------------------------------------------------------
    // message builders
    // ------------------------------------------------------------------

    // random version, type and message id around a chosen token length and code
    function automatic void push_header(logic [3:0] tkl, logic [7:0] code);
        logic [7:0] b0;
        b0 = 8'($urandom_range(0, 255));
        b0[3:0] = tkl;
        msg_q.push_back(b0);
        msg_q.push_back(code);
        msg_q.push_back(8'($urandom_range(0, 255)));
        msg_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    // option header plus extended delta/length bytes, then n_value random value bytes
    function automatic void add_option(int unsigned delta, int unsigned len,
                                       int unsigned n_value);
        logic [3:0]  dn;
        logic [3:0]  ln;
        logic [15:0] ext;
        dn = (delta < EXT1_BIAS) ? delta[3:0] : (delta < EXT2_BIAS) ? NIB_EXT1 : NIB_EXT2;
        ln = (len < EXT1_BIAS) ? len[3:0] : (len < EXT2_BIAS) ? NIB_EXT1 : NIB_EXT2;
        msg_q.push_back({dn, ln});
        if (dn == NIB_EXT1) begin
            ext = 16'(delta - EXT1_BIAS);
            msg_q.push_back(ext[7:0]);
        end else if (dn == NIB_EXT2) begin
            ext = 16'(delta - EXT2_BIAS);
            msg_q.push_back(ext[15:8]);
            msg_q.push_back(ext[7:0]);
        end
        if (ln == NIB_EXT1) begin
            ext = 16'(len - EXT1_BIAS);
            msg_q.push_back(ext[7:0]);
        end else if (ln == NIB_EXT2) begin
            ext = 16'(len - EXT2_BIAS);
            msg_q.push_back(ext[15:8]);
            msg_q.push_back(ext[7:0]);
        end
        repeat (n_value) msg_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    // well-formed message with random content; rare wide deltas may overflow
    function automatic void build_wellformed();
        logic [3:0]  tkl;
        logic [7:0]  code;
        int unsigned delta;
        int unsigned len;
        int unsigned pct;
        msg_q.delete();
        tkl  = ($urandom_range(0, 99) < 88) ? 4'($urandom_range(0, 8))
                                            : 4'($urandom_range(9, 15));
        code = ($urandom_range(0, 99) < 6) ? 8'h00 : 8'($urandom_range(1, 255));
        push_header(tkl, code);
        if (code == 8'h00)
            return;
        repeat (tkl) msg_q.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 4)) begin
            pct = $urandom_range(0, 99);
            if (pct < 55)      delta = $urandom_range(0, 12);
            else if (pct < 85) delta = $urandom_range(13, 268);
            else if (pct < 97) delta = $urandom_range(269, 2000);
            else               delta = $urandom_range(269, 65804);
            pct = $urandom_range(0, 99);
            if (pct < 82)      len = $urandom_range(0, 12);
            else if (pct < 97) len = $urandom_range(13, 40);
            else if (big_left > 0) begin
                len = $urandom_range(269, 300);
                big_left--;
            end else           len = $urandom_range(0, 4);
            add_option(delta, len, len);
        end
        if ($urandom_range(0, 1) == 1) begin
            msg_q.push_back(8'hFF);
            repeat ($urandom_range(1, 8)) msg_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // targeted broken framing: huge truncated length, reserved length, delta overflow
    function automatic void build_special();
        msg_q.delete();
        push_header(4'h0, 8'($urandom_range(1, 255)));
        case ($urandom_range(0, 2))
            0: begin
                msg_q.push_back({4'($urandom_range(0, 12)), NIB_EXT2});
                if ($urandom_range(0, 4) == 0) begin
                    msg_q.push_back(8'hFF);
                    msg_q.push_back(8'hFF);
                end else begin
                    msg_q.push_back(8'($urandom_range(0, 255)));
                    msg_q.push_back(8'($urandom_range(0, 255)));
                end
                repeat ($urandom_range(0, 3)) msg_q.push_back(8'($urandom_range(0, 255)));
            end
            1: begin
                add_option($urandom_range(0, 30), 0, 0);
                msg_q.push_back({4'($urandom_range(0, 14)), NIB_RES});
                repeat ($urandom_range(0, 2)) msg_q.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                add_option($urandom_range(60000, 65535), 0, 0);
                add_option($urandom_range(269, 65804), $urandom_range(0, 3), 2);
                repeat ($urandom_range(0, 2)) msg_q.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    function automatic void build_noise();
        msg_q.delete();
        repeat ($urandom_range(1, 12)) msg_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    // cut the tail off or overwrite one byte
    function automatic void mutate();
        int unsigned m;
        m = $urandom_range(0, 99);
        if (m < 15 && msg_q.size() > 1)
            msg_q = msg_q[0:$urandom_range(0, msg_q.size() - 2)];
        else if (m < 25)
            msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send_byte(logic [7:0] b, logic last);
        while (!no_idle_window() && $urandom_range(0, 99) < 37) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(b, last);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_msg();
        foreach (msg_q[i])
            send_byte(msg_q[i], i == msg_q.size() - 1);
    endtask

    // receiver: random stalls plus one long hold-off so the input side backs up
    initial begin
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!holdoff_done && n_sent >= 300) begin
                holdoff_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (150) @(negedge i_clk);
            end
            i_out_ready <= no_idle_window() || $urandom_range(0, 99) >= 37;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : result_mon
        t_result seen;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.rkind         = o_rkind;
            seen.version       = o_version;
            seen.msg_type      = o_msg_type;
            seen.token_len     = o_token_len;
            seen.code_class    = o_code_class;
            seen.code_detail   = o_code_detail;
            seen.message_id    = o_message_id;
            seen.data_byte     = o_data_byte;
            seen.option_number = o_option_number;
            seen.option_length = o_option_length;
            seen.option_int    = o_option_int;
            sb.check_result(seen, o_last_of_run);
        end
    end

    initial begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_byte    = 8'h00;
        i_in_last    = 1'b0;
        n_sent       = 0;
        big_left     = 2;
        holdoff_done = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // short message
        msg_q = '{8'h40};
        send_msg();
        // empty message code 0.00 with a trailing byte
        msg_q = '{8'h40, 8'h00, 8'h00, 8'h00, 8'h01};
        send_msg();
        // all ones header: token length 15, ends right after the header
        msg_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_msg();
        // token, one-byte extended delta, one value byte, marker with no payload
        msg_q = '{8'h41, 8'h01, 8'h12, 8'h34, 8'hAA, 8'hD1, 8'h00, 8'h7F, 8'hFF};
        send_msg();
        // reserved delta nibble, then a swallowed byte
        msg_q = '{8'h50, 8'h02, 8'h00, 8'h01, 8'hF0, 8'h00};
        send_msg();

        while (n_sent < 1900) begin
            case ($urandom_range(0, 99)) inside
                [0:69]: begin
                    build_wellformed();
                    mutate();
                end
                [70:84]: build_noise();
                default: build_special();
            endcase
            send_msg();
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.n_errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

### files.f
sv/cmp_pkg.sv
sv/cmp_front.sv
sv/cmp_queue.sv
sv/cmp_back.sv
sv/coap_message_parser.sv
tb/coap_parse_scoreboard_pkg.sv
tb/tb.sv
